// ===== sv/dtw_pkg.sv =====
// ----------------------------------------------------------------------------
// dtw_pkg
// shared types and constants of the dtw distance unit: field widths, command
// and register codes, and the control word that rides along the cell chain
// ----------------------------------------------------------------------------
package dtw_pkg;

	// fixed field widths
	localparam int POS_BITS     = 8;
	localparam int DIST_BITS    = 48;
	localparam int REF_LEN_BITS = 9;
	localparam int QLEN_BITS    = 16;
	localparam int PADDR_BITS   = 3;
	localparam int PDATA_BITS   = 32;

	// register reset values
	localparam logic [REF_LEN_BITS-1:0] REF_LENGTH_RST   = 9'd256;
	localparam logic [QLEN_BITS-1:0]    QUERY_LENGTH_RST = 16'd1;

	// command carried on tuser of the input stream
	typedef enum logic {
		CMD_REF_WRITE = 1'b0,
		CMD_QUERY     = 1'b1
	} cmd_t;

	// register index, taken from paddr[2]
	typedef enum logic {
		REG_REF_LENGTH   = 1'b0,
		REG_QUERY_LENGTH = 1'b1
	} reg_idx_t;

	// configuration as seen by the datapath
	typedef struct packed {
		logic [REF_LEN_BITS-1:0] ref_length;
		logic [QLEN_BITS-1:0]    query_length;
	} cfg_t;

	// control word traveling with each token through the chain
	typedef struct packed {
		logic                valid;
		logic                is_query;
		logic                first;     // first column of a comparison
		logic                done;      // column ends the comparison
		logic                sat;       // saturation seen in this column
		logic [POS_BITS-1:0] pos;       // target cell of a reference write
	} tok_ctl_t;

endpackage

// ===== sv/dtw_regs.sv =====
// ----------------------------------------------------------------------------
// dtw_regs
// apb register file holding reference length and query length
// ----------------------------------------------------------------------------
module dtw_regs
	import dtw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [PDATA_BITS-1:0] pwdata,
	output logic [PDATA_BITS-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	logic [REF_LEN_BITS-1:0] ref_length_q;
	logic [QLEN_BITS-1:0]    query_length_q;
	logic                    wr_en;
	reg_idx_t                reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_length_q   <= REF_LENGTH_RST;
			query_length_q <= QUERY_LENGTH_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_REF_LENGTH:   ref_length_q   <= pwdata[REF_LEN_BITS-1:0];
				REG_QUERY_LENGTH: query_length_q <= pwdata[QLEN_BITS-1:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_REF_LENGTH:   prdata = PDATA_BITS'(ref_length_q);
			REG_QUERY_LENGTH: prdata = PDATA_BITS'(query_length_q);
			default:          prdata = '0;
		endcase
	end

	assign cfg.ref_length   = ref_length_q;
	assign cfg.query_length = query_length_q;

endmodule

// ===== sv/dtw_cell.sv =====
// ----------------------------------------------------------------------------
// dtw_cell
// one row of the warping matrix: holds a reference sample and the last cost
// of its row, squares the difference in stage 1, adds the minimum neighbor
// cost in stage 2, hands below and diagonal costs to the next row
// ----------------------------------------------------------------------------
module dtw_cell
	import dtw_pkg::*;
#(
	parameter int IDX         = 0,
	parameter int IDX_BITS    = 8,
	parameter int SAMPLE_BITS = 16,
	parameter int COST_BITS   = 48
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [IDX_BITS-1:0]           last_idx,
	input  tok_ctl_t                      ctl_in,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic [COST_BITS-1:0]          below_in,
	input  logic [COST_BITS-1:0]          diag_in,
	input  logic [COST_BITS-1:0]          dist_in,
	output tok_ctl_t                      ctl_out,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output logic [COST_BITS-1:0]          below_out,
	output logic [COST_BITS-1:0]          diag_out,
	output logic [COST_BITS-1:0]          dist_out
);

	localparam int SQ_BITS = 2 * (SAMPLE_BITS + 1);
	localparam int WIDE    = (SQ_BITS > COST_BITS) ? SQ_BITS : COST_BITS;
	localparam bit IS_HEAD = (IDX == 0);

	logic signed [SAMPLE_BITS-1:0] ref_q;
	logic [COST_BITS-1:0]          cost_q;

	// stage 1 signals
	logic signed [SAMPLE_BITS:0] diff;
	logic [SAMPLE_BITS:0]        mag;
	logic [SQ_BITS-1:0]          sq;
	logic [WIDE-1:0]             sq_w;
	logic [COST_BITS-1:0]        cost_max;
	logic                        c_sat;
	logic [COST_BITS-1:0]        c_val;
	logic                        wr_hit;

	tok_ctl_t                      ctl_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic [COST_BITS-1:0]          below_s1;
	logic [COST_BITS-1:0]          diag_s1;
	logic [COST_BITS-1:0]          dist_s1;
	logic [COST_BITS-1:0]          c_s1;
	logic                          csat_s1;

	// stage 2 signals
	logic                 in_use;
	logic                 is_last;
	logic                 qv;
	logic [COST_BITS-1:0] min3;
	logic [COST_BITS-1:0] add_b;
	logic [COST_BITS:0]   sum;
	logic                 ovf;
	logic [COST_BITS-1:0] v;
	tok_ctl_t             ctl_nxt;

	tok_ctl_t                      ctl_s2;
	logic signed [SAMPLE_BITS-1:0] sample_s2;
	logic [COST_BITS-1:0]          below_s2;
	logic [COST_BITS-1:0]          diag_s2;
	logic [COST_BITS-1:0]          dist_s2;

	// local cost, squared difference with saturation
	always_comb begin
		diff     = {ref_q[SAMPLE_BITS-1], ref_q} - {sample_in[SAMPLE_BITS-1], sample_in};
		mag      = diff[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-diff) : (SAMPLE_BITS+1)'(diff);
		sq       = mag * mag;
		sq_w     = WIDE'(sq);
		cost_max = '1;
		c_sat    = sq_w > WIDE'(cost_max);
		c_val    = c_sat ? cost_max : sq_w[COST_BITS-1:0];
	end

	assign wr_hit = ctl_in.valid && !ctl_in.is_query && (32'(ctl_in.pos) == IDX);

	// neighbor choice and saturating add
	always_comb begin
		in_use  = last_idx >= IDX_BITS'(IDX);
		is_last = last_idx == IDX_BITS'(IDX);
		qv      = ctl_s1.valid && ctl_s1.is_query && in_use;

		min3 = cost_q;
		if (below_s1 < min3) min3 = below_s1;
		if (diag_s1 < min3) min3 = diag_s1;

		priority if (ctl_s1.first) begin
			add_b = IS_HEAD ? '0 : below_s1;
		end else if (IS_HEAD) begin
			add_b = cost_q;
		end else begin
			add_b = min3;
		end

		sum = {1'b0, c_s1} + {1'b0, add_b};
		ovf = sum[COST_BITS];
		v   = ovf ? cost_max : sum[COST_BITS-1:0];

		ctl_nxt     = ctl_s1;
		ctl_nxt.sat = ctl_s1.sat || (qv && (ovf || csat_s1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sample_s1 <= sample_in;
			below_s1  <= below_in;
			diag_s1   <= diag_in;
			dist_s1   <= dist_in;
			c_s1      <= c_val;
			csat_s1   <= c_sat;
			if (wr_hit) ref_q <= sample_in;

			sample_s2 <= sample_s1;
			below_s2  <= v;
			diag_s2   <= cost_q;
			dist_s2   <= (qv && is_last) ? v : dist_s1;
			if (qv) cost_q <= v;
		end
	end

	assign ctl_out    = ctl_s2;
	assign sample_out = sample_s2;
	assign below_out  = below_s2;
	assign diag_out   = diag_s2;
	assign dist_out   = dist_s2;

endmodule

// ===== sv/dtw_distance_unit.sv =====
// ----------------------------------------------------------------------------
// dtw_distance_unit
// dynamic time warping distance, squared sample difference, streamed by
// query columns through a chain of one cell per reference row
// ----------------------------------------------------------------------------
//  port group   dir   carries
//  s_*          in    reference write or query word (tuser = command)
//  m_*          out   distance word, tlast = complete, tuser = saturated
//  p*           in    apb registers: ref_length at 0x0, query_length at 0x4
//
//  one input word per cycle, back to back while the output is not stalled;
//  each word walks the cell chain, two registers per cell, and a query result
//  leaves through the output register; the chain length sets the latency
//  no clearing pass after reset; reference and cost stores hold garbage
//  until written
//  a stalled output freezes the whole chain and drops s_tready
// ----------------------------------------------------------------------------
module dtw_distance_unit
	import dtw_pkg::*;
#(
	parameter int MAX_REF_LEN = 256,
	parameter int SAMPLE_BITS = 16,
	parameter int COST_BITS   = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// position [7:0], sample [8+SAMPLE_BITS-1:8], zero pad to bytes
	input  logic [((POS_BITS+SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
	// command
	input  logic                  s_tuser,
	// output stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// distance [47:0]
	output logic [DIST_BITS-1:0]  m_tdata,
	// complete
	output logic                  m_tlast,
	// saturated
	output logic                  m_tuser,
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [PDATA_BITS-1:0] pwdata,
	output logic [PDATA_BITS-1:0] prdata,
	output logic                  pready
);

	localparam int IDX_BITS = $clog2(MAX_REF_LEN);

	cfg_t                  cfg;
	logic [IDX_BITS-1:0]   last_idx;     // row whose cost is the distance
	logic [QLEN_BITS-1:0]  qlen_eff;
	logic                  adv;          // whole chain steps forward
	logic                  in_fire;
	logic                  q_done;
	cmd_t                  cmd;

	logic [QLEN_BITS-1:0]  cnt_q;        // query words seen in this comparison
	logic                  sat_seen_q;   // saturation across earlier columns

	logic                  out_valid_q;
	logic [DIST_BITS-1:0]  out_dist_q;
	logic                  out_last_q;
	logic                  out_sat_q;

	// chain links, index k feeds cell k
	tok_ctl_t                      ctl_w    [MAX_REF_LEN+1];
	logic signed [SAMPLE_BITS-1:0] sample_w [MAX_REF_LEN+1];
	logic [COST_BITS-1:0]          below_w  [MAX_REF_LEN+1];
	logic [COST_BITS-1:0]          diag_w   [MAX_REF_LEN+1];
	logic [COST_BITS-1:0]          dist_w   [MAX_REF_LEN+1];

	tok_ctl_t exit_ctl;
	logic     exit_query;

	dtw_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// clamp the lengths: zero acts as one, long references as the chain length
	always_comb begin
		priority if (cfg.ref_length == '0) begin
			last_idx = '0;
		end else if (32'(cfg.ref_length) > MAX_REF_LEN) begin
			last_idx = IDX_BITS'(MAX_REF_LEN - 1);
		end else begin
			last_idx = IDX_BITS'(cfg.ref_length - 1'b1);
		end
		qlen_eff = (cfg.query_length == '0) ? QLEN_BITS'(1) : cfg.query_length;
	end

	// the output register parts the chain from the consumer
	assign adv      = !(out_valid_q && !m_tready);
	assign s_tready = adv;
	assign in_fire  = s_tvalid && s_tready;
	assign cmd      = cmd_t'(s_tuser);
	assign q_done   = ({1'b0, cnt_q} + 1'b1) >= {1'b0, qlen_eff};

	// head of the chain: new token, no neighbor costs yet
	always_comb begin
		ctl_w[0].valid    = in_fire;
		ctl_w[0].is_query = (cmd == CMD_QUERY);
		ctl_w[0].first    = (cnt_q == '0);
		ctl_w[0].done     = q_done;
		ctl_w[0].sat      = 1'b0;
		ctl_w[0].pos      = s_tdata[POS_BITS-1:0];
		sample_w[0]       = s_tdata[POS_BITS +: SAMPLE_BITS];
		below_w[0]        = '0;
		diag_w[0]         = '0;
		dist_w[0]         = '0;
	end

	// query position within the comparison
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_fire && cmd == CMD_QUERY) begin
			cnt_q <= q_done ? '0 : cnt_q + 1'b1;
		end
	end

	// one cell per reference row
	for (genvar k = 0; k < MAX_REF_LEN; k++) begin : g_cell
		dtw_cell #(
			.IDX         (k),
			.IDX_BITS    (IDX_BITS),
			.SAMPLE_BITS (SAMPLE_BITS),
			.COST_BITS   (COST_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (adv),
			.last_idx   (last_idx),
			.ctl_in     (ctl_w[k]),
			.sample_in  (sample_w[k]),
			.below_in   (below_w[k]),
			.diag_in    (diag_w[k]),
			.dist_in    (dist_w[k]),
			.ctl_out    (ctl_w[k+1]),
			.sample_out (sample_w[k+1]),
			.below_out  (below_w[k+1]),
			.diag_out   (diag_w[k+1]),
			.dist_out   (dist_w[k+1])
		);
	end

	// tail: reference writes vanish, query columns become result words
	assign exit_ctl   = ctl_w[MAX_REF_LEN];
	assign exit_query = exit_ctl.valid && exit_ctl.is_query;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sat_seen_q  <= 1'b0;
		end else if (adv) begin
			out_valid_q <= exit_query;
			if (exit_query) begin
				sat_seen_q <= exit_ctl.done ? 1'b0 : (sat_seen_q || exit_ctl.sat);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && exit_query) begin
			out_dist_q <= DIST_BITS'(dist_w[MAX_REF_LEN]);
			out_last_q <= exit_ctl.done;
			out_sat_q  <= sat_seen_q || exit_ctl.sat;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_dist_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_sat_q;

	// a stalled result freezes the chain tail
	a_stall_holds_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(exit_ctl))
		else $error("chain moved while output stalled");

	// a reference write leaving the chain produces no word
	a_write_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && exit_ctl.valid && !exit_ctl.is_query) |=> !m_tvalid)
		else $error("reference write produced an output word");

	// a completing column clears the saturation tracker
	a_done_clears_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && exit_query && exit_ctl.done) |=> !sat_seen_q)
		else $error("saturation flag survived comparison end");

	// result word carries the saturation of its column
	a_sat_reported: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && exit_query && exit_ctl.sat) |=> m_tuser)
		else $error("column saturation not reported");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the dtw distance unit: a directed table, then
// random phases of reference writes and query words under changing register
// settings, every distance word compared with the table or an in-bench column predictor
// ----------------------------------------------------------------------------
module tb_top;
	import dtw_pkg::*;

	localparam int ROWS          = 256;
	localparam int CHAIN_LATENCY = 2 * ROWS;       // registers in the cell chain
	localparam int CYCLE_LIMIT   = 300000;
	localparam int PHASES        = 18;
	localparam int PHASE_WORDS   = 100;

	// one distance word as the block should return it
	typedef struct {
		logic [DIST_BITS-1:0] dval;
		logic                 last;
		logic                 sat;
	} dist_word_t;

	// one row of the directed table: either an input word or a register write
	typedef enum logic { ROW_WORD, ROW_REG } row_kind_t;
	typedef struct packed {
		row_kind_t            kind;
		cmd_t                 cmd;
		logic [7:0]           pos;
		logic [15:0]          samp;
		reg_idx_t             regsel;
		logic [31:0]          value;
		logic                 typed;   // distance word below is known up front
		logic [DIST_BITS-1:0] dval;
		logic                 last;
	} stim_row_t;

	localparam int NUM_DIRECTED = 27;

	// directed table
	//  single reference row: extreme samples give the largest and the zero cost
	//  register value zero acts as one for both registers
	//  reference write in the middle of a comparison is used from the next column
	//  shorter query length mid comparison closes it at once
	//  fewer reference rows mid comparison
	stim_row_t directed_rows [0:NUM_DIRECTED-1] = '{
		'{ROW_REG,  CMD_QUERY,     8'd0,   16'h0000, REG_REF_LENGTH,   32'd1, 1'b0, 48'd0, 1'b0},
		'{ROW_REG,  CMD_QUERY,     8'd0,   16'h0000, REG_QUERY_LENGTH, 32'd1, 1'b0, 48'd0, 1'b0},
		'{ROW_WORD, CMD_REF_WRITE, 8'd0,   16'h7FFF, REG_REF_LENGTH,   32'd0, 1'b0, 48'd0, 1'b0},
		'{ROW_WORD, CMD_QUERY,     8'd0,   16'h8000, REG_REF_LENGTH,   32'd0, 1'b1,
			48'd4294836225, 1'b1},
		'{ROW_WORD, CMD_QUERY,     8'd255, 16'h7FFF, REG_REF_LENGTH,   32'd0, 1'b1, 48'd0, 1'b1},
		'{ROW_REG,  CMD_QUERY,     8'd0,   16'h0000, REG_REF_LENGTH,   32'd0, 1'b0, 48'd0, 1'b0},
		'{ROW_REG,  CMD_QUERY,     8'd0,   16'h0000, REG_QUERY_LENGTH, 32'd0, 1'b0, 48'd0, 1'b0},
		'{ROW_WORD, CMD_QUERY,     8'd0,   16'h0000, REG_REF_LENGTH,   32'd0, 1'b1,
			48'd1073676289, 1'b1},
		'{ROW_WORD, CMD_REF_WRITE, 8'd255, 16'h8000, REG_REF_LENGTH,   32'd0, 1'b0, 48'd0, 1'b0},
		'{ROW_WORD, CMD_REF_WRITE, 8'd1,   16'hFFFF, REG_REF_LENGTH,   32'd0, 1'b0, 48'd0, 1'b0},
		'{ROW_REG,  CMD_QUERY,     8'd0,   16'h0000, REG_REF_LENGTH,   32'd2, 1'b0, 48'd0, 1'b0},
		'{ROW_REG,  CMD_QUERY,     8'd0,   16'h0000, REG_QUERY_LENGTH, 32'd3, 1'b0, 48'd0, 1'b0},
		'{ROW_WORD, CMD_QUERY,     8'hAA,  16'h0000, REG_REF_LENGTH,   32'd0, 1'b0, 48'd0, 1'b0},
		'{ROW_WORD, CMD_QUERY,     8'h55,  16'hFFFF, REG_REF_LENGTH,   32'd0, 1'b0, 48'd0, 1'b0},
		'{ROW_WORD, CMD_REF_WRITE, 8'd0,   16'h0005, REG_REF_LENGTH,   32'd0, 1'b0, 48'd0, 1'b0},
		'{ROW_WORD, CMD_QUERY,     8'd0,   16'h0001, REG_REF_LENGTH,   32'd0, 1'b0, 48'd0, 1'b0},
		'{ROW_WORD, CMD_QUERY,     8'd0,   16'h4000, REG_REF_LENGTH,   32'd0, 1'b0, 48'd0, 1'b0},
		'{ROW_REG,  CMD_QUERY,     8'd0,   16'h0000, REG_QUERY_LENGTH, 32'd1, 1'b0, 48'd0, 1'b0},
		'{ROW_WORD, CMD_QUERY,     8'd0,   16'hC000, REG_REF_LENGTH,   32'd0, 1'b0, 48'd0, 1'b0},
		'{ROW_WORD, CMD_QUERY,     8'd0,   16'd100,  REG_REF_LENGTH,   32'd0, 1'b0, 48'd0, 1'b0},
		'{ROW_REG,  CMD_QUERY,     8'd0,   16'h0000, REG_QUERY_LENGTH, 32'd4, 1'b0, 48'd0, 1'b0},
		'{ROW_WORD, CMD_QUERY,     8'd0,   16'd7,    REG_REF_LENGTH,   32'd0, 1'b0, 48'd0, 1'b0},
		'{ROW_REG,  CMD_QUERY,     8'd0,   16'h0000, REG_REF_LENGTH,   32'd1, 1'b0, 48'd0, 1'b0},
		'{ROW_WORD, CMD_QUERY,     8'd0,   16'hFFF9, REG_REF_LENGTH,   32'd0, 1'b0, 48'd0, 1'b0},
		'{ROW_WORD, CMD_QUERY,     8'd0,   16'h7FFF, REG_REF_LENGTH,   32'd0, 1'b0, 48'd0, 1'b0},
		'{ROW_REG,  CMD_QUERY,     8'd0,   16'h0000, REG_QUERY_LENGTH, 32'd2, 1'b0, 48'd0, 1'b0},
		'{ROW_WORD, CMD_QUERY,     8'd0,   16'h8000, REG_REF_LENGTH,   32'd0, 1'b0, 48'd0, 1'b0}
	};

	// clock, reset and block inputs, all known from time zero
	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [23:0]           s_tdata  = '0;   // position [7:0], sample [23:8]
	logic                  s_tuser  = 1'b0; // command
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [DIST_BITS-1:0]  m_tdata;         // distance [47:0]
	logic                  m_tlast;         // complete
	logic                  m_tuser;         // saturated
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [PADDR_BITS-1:0] paddr    = '0;
	logic [PDATA_BITS-1:0] pwdata   = '0;
	logic [PDATA_BITS-1:0] prdata;
	logic                  pready;

	// predictor state: reference rows, cost column, comparison progress
	logic [15:0]             ref_rows   [ROWS];
	bit                      ref_seen   [ROWS];
	logic [DIST_BITS-1:0]    cost_col   [ROWS];
	int                      cost_rows  = 0;    // cost rows written so far (a prefix)
	int unsigned             q_count    = 0;
	bit                      sat_flag   = 1'b0;
	logic [REF_LEN_BITS-1:0] cfg_ref_len = REF_LENGTH_RST;
	logic [QLEN_BITS-1:0]    cfg_qlen    = QUERY_LENGTH_RST;

	dist_word_t expected_dist [$];   // distance words still owed by the block
	int         errors         = 0;
	int         cycles         = 0;
	int         send_idle_pct  = 0;
	int         recv_idle_pct  = 0;

	dtw_distance_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("dtw_distance_unit verification failed");
			$finish;
		end
	end

	// receiver back-pressure, changed on the falling edge
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// reference rows in use: zero counts as one, above the store counts as full
	function automatic int rows_in_use(logic [REF_LEN_BITS-1:0] len);
		if (len < 1)
			return 1;
		if (len > ROWS)
			return ROWS;
		return int'(len);
	endfunction

	// saturating cost sum
	function automatic logic [DIST_BITS-1:0] cost_add(logic [DIST_BITS-1:0] a,
			logic [DIST_BITS-1:0] b);
		logic [DIST_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s[DIST_BITS]) begin
			sat_flag = 1'b1;
			return '1;
		end
		return s[DIST_BITS-1:0];
	endfunction

	// one query sample: new cost column, distance in the last row in use
	function automatic dist_word_t next_column(logic [15:0] q);
		dist_word_t           w;
		int                   n;
		int                   qlen;
		int                   i;
		bit                   first;
		logic signed [16:0]   d;
		logic [16:0]          ad;
		logic [33:0]          sq;
		logic [DIST_BITS-1:0] c, old, m, v, diag, below;
		n     = rows_in_use(cfg_ref_len);
		qlen  = (cfg_qlen == 0) ? 1 : int'(cfg_qlen);
		first = (q_count == 0);
		diag  = '0;
		below = '0;
		for (i = 0; i < n; i++) begin
			d   = $signed({ref_rows[i][15], ref_rows[i]}) - $signed({q[15], q});
			ad  = (d < 0) ? -d : d;
			sq  = ad * ad;
			c   = {{(DIST_BITS-34){1'b0}}, sq};
			old = cost_col[i];
			if (first) begin
				v = (i == 0) ? c : cost_add(c, below);
			end else if (i == 0) begin
				v = cost_add(c, old);
			end else begin
				m = old;
				if (below < m)
					m = below;
				if (diag < m)
					m = diag;
				v = cost_add(c, m);
			end
			diag        = old;
			below       = v;
			cost_col[i] = v;
		end
		if (n > cost_rows)
			cost_rows = n;
		w.dval = cost_col[n-1];
		w.last = (q_count + 1 >= qlen);
		w.sat  = sat_flag;
		if (w.last) begin
			q_count  = 0;
			sat_flag = 1'b0;
		end else begin
			q_count = (q_count + 1) & 16'hFFFF;
		end
		return w;
	endfunction

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// drop s_tvalid and let the falling edge pass
	task automatic quiet_input();
		s_tvalid <= 1'b0;
		@(negedge clk);
	endtask

	// offer one input word, with a random gap ahead of it
	task automatic send_word(cmd_t cmd, logic [7:0] pos, logic [15:0] samp, logic typed,
			logic [DIST_BITS-1:0] tdist, logic tlast);
		dist_word_t w;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {samp, pos};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		// word taken: update the predictor and owe a distance word for a query
		if (cmd == CMD_REF_WRITE) begin
			ref_rows[pos] = samp;
			ref_seen[pos] = 1'b1;
		end else begin
			w = next_column(samp);
			if (typed) begin
				w.dval = tdist;
				w.last = tlast;
				w.sat  = 1'b0;
			end
			expected_dist.push_back(w);
		end
		@(negedge clk);
	endtask

	// hold the input until every owed distance word has come back
	task automatic wait_drained();
		quiet_input();
		while (expected_dist.size() != 0)
			@(negedge clk);
	endtask

	// apb read, checked against the register copy
	task automatic read_register(reg_idx_t idx);
		logic [PDATA_BITS-1:0] want;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		want = (idx == REG_REF_LENGTH) ? PDATA_BITS'(cfg_ref_len) : PDATA_BITS'(cfg_qlen);
		if (prdata !== want) begin
			$display("%0t register %s readback: expected %0d got %0d",
				$time, idx.name(), want, prdata);
			errors++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// apb write once the chain is empty, then read it back
	task automatic set_register(reg_idx_t idx, logic [31:0] value);
		wait_drained();
		// reference writes return nothing, so let the chain run dry
		repeat (CHAIN_LATENCY + 8)
			@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (idx == REG_REF_LENGTH)
			cfg_ref_len = value[REF_LEN_BITS-1:0];
		else
			cfg_qlen = value[QLEN_BITS-1:0];
		@(negedge clk);
		read_register(idx);
	endtask

	// distance word check, oldest expectation first
	always @(posedge clk) begin : result_check
		dist_word_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_dist.size() == 0) begin
				$display("%0t unexpected distance word: expected none got %0d",
					$time, m_tdata);
				errors++;
			end else begin
				e = expected_dist.pop_front();
				if (m_tdata !== e.dval) begin
					$display("%0t distance: expected %0d got %0d", $time, e.dval, m_tdata);
					errors++;
				end
				if (m_tlast !== e.last) begin
					$display("%0t complete: expected %0b got %0b", $time, e.last, m_tlast);
					errors++;
				end
				if (m_tuser !== e.sat) begin
					$display("%0t saturated: expected %0b got %0b", $time, e.sat, m_tuser);
					errors++;
				end
			end
		end
	end

	initial begin
		int p, k, i;
		int rl, ql;
		stim_row_t r;

		repeat (4)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset values of both registers
		read_register(REG_REF_LENGTH);
		read_register(REG_QUERY_LENGTH);

		// directed table, sender slow-ish and receiver stalling half the time
		send_idle_pct = 18;
		recv_idle_pct = 52;
		for (i = 0; i < NUM_DIRECTED; i++) begin
			r = directed_rows[i];
			if (r.kind == ROW_REG)
				set_register(r.regsel, r.value);
			else
				send_word(r.cmd, r.pos, r.samp, r.typed, r.dval, r.last);
		end

		// random phases: idling swaps sides after a third, then stops
		for (p = 0; p < PHASES; p++) begin
			if (p == PHASES / 3) begin
				send_idle_pct = 52;
				recv_idle_pct = 18;
			end else if (p == 2 * PHASES / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			// register settings: extremes and out-of-range values first
			case (p)
				0: begin rl = 256; ql = 5; end
				1: begin rl = 1; ql = 1; end
				2: begin rl = 511; ql = 65535; end
				3: begin rl = 0; ql = 0; end
				4: begin rl = 300; ql = 3; end
				6: begin rl = 256; ql = 1; end
				7: begin rl = 2; ql = 65535; end
				default: begin
					if ($urandom_range(9) == 0)
						rl = $urandom_range(511, 257);
					else
						rl = $urandom_range(256, 1);
					ql = $urandom_range(16, 1);
				end
			endcase
			// mid comparison, rows never filled in the cost column must stay out
			if (q_count != 0 && rows_in_use(REF_LEN_BITS'(rl)) > cost_rows)
				rl = cost_rows;
			set_register(REG_REF_LENGTH, rl);
			set_register(REG_QUERY_LENGTH, ql);

			// every reference row in use is written before any query reads it
			for (i = 0; i < rows_in_use(cfg_ref_len); i++) begin
				if (!ref_seen[i])
					send_word(CMD_REF_WRITE, 8'(i), rand_sample(), 1'b0, '0, 1'b0);
			end

			for (k = 0; k < PHASE_WORDS; k++) begin
				// sender waits out every owed word once per phase
				if (k == PHASE_WORDS / 2)
					wait_drained();
				if ($urandom_range(99) < 40)
					send_word(CMD_REF_WRITE, 8'($urandom_range(255)), rand_sample(),
						1'b0, '0, 1'b0);
				else
					send_word(CMD_QUERY, 8'($urandom_range(255)), rand_sample(),
						1'b0, '0, 1'b0);
			end
		end

		// drain, then give stray words time to show up
		wait_drained();
		repeat (CHAIN_LATENCY + 16)
			@(negedge clk);
		if (errors == 0 && expected_dist.size() == 0) begin
			$display("dtw_distance_unit verification clean");
		end else begin
			$display("dtw_distance_unit verification failed");
		end
		$finish;
	end

endmodule
